FILE: hdl/sle_pkg.sv
// Shared types and constants for the sorted list engine.
// No dependencies; imported by every module of the block.
package sle_pkg;

	// Number of values the list can hold
	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int VAL_W    = 32;
	localparam int COUNT_W  = 5;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [IDX_W-1:0]        idx_t;

	// Request codes
	localparam logic [1:0] REQ_INS  = 2'd0;
	localparam logic [1:0] REQ_DEL  = 2'd1;
	localparam logic [1:0] REQ_DUMP = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// Cell operations broadcast along the chain
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_INS  = 2'd1;
	localparam logic [1:0] OP_DEL  = 2'd2;
	localparam logic [1:0] OP_ROT  = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		val_t       key;
	} sle_cmd_t;

endpackage

FILE: hdl/sorted_list_engine_core.sv
// Sorted list engine top level: request sequencer, result register, cell chain.
// Depends on sle_pkg and sle_chain.
//
//  channel | signals                         | handshake
//  --------+---------------------------------+------------------------------
//  request | req_type, value                 | taken when start && !busy
//  result  | item, count, status, last       | valid high, no stall
//
// Insert and delete register the request, then do the parallel compare-and-shift
// across all cells; the result beat shows the cycle after.
// A dump of n held values registers the request and decodes it, then the chain
// rotates one value to the head per cycle, and after n rotations the order is
// back where it started.
// Reset clears the sequencer and the held count; cell contents are unknown until written.
// The receiver cannot stall: each result beat is valid for exactly one cycle.
module sorted_list_engine_core import sle_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] value,
	output logic               valid,
	output logic signed [31:0] item,
	output logic [4:0]         count,
	output logic [1:0]         status,
	output logic               last
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DUMP = 2'd2;

	logic [1:0]         state_q, state_d;
	logic [1:0]         req_q;
	val_t               key_q;
	cnt_t               cnt_q, cnt_d;
	idx_t               idx_q, idx_d;
	sle_cmd_t           cmd;
	val_t               head;
	logic               found;
	logic               full;
	logic               dump_last;
	logic               res_v;
	val_t               res_item;
	logic [1:0]         res_status;
	logic               res_last;
	logic [CNT_W+4:0]   cnt_wide;

	logic               valid_q;
	val_t               item_q;
	logic [COUNT_W-1:0] count_q;
	logic [1:0]         status_q;
	logic               last_q;

	assign full      = (cnt_q == cnt_t'(CAPACITY));
	assign dump_last = (cnt_t'(idx_q) + cnt_t'(1)) == cnt_q;
	assign busy      = (state_q != S_IDLE);

	sle_chain u_chain (
		.clk  (clk),
		.cmd  (cmd),
		.cnt  (cnt_q),
		.head (head),
		.found(found)
	);

	// Sequencer: next state, chain command and result beat
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		cmd.op     = OP_HOLD;
		cmd.key    = key_q;
		res_v      = 1'b0;
		res_item   = key_q;
		res_status = ST_OK;
		res_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_IDLE;
				unique case (req_q)
					REQ_INS: begin
						res_v = 1'b1;
						if (full) begin
							res_status = ST_FULL;
						end else begin
							cmd.op = OP_INS;
							cnt_d  = cnt_q + cnt_t'(1);
						end
					end
					REQ_DEL: begin
						res_v  = 1'b1;
						cmd.op = OP_DEL;
						if (found)
							cnt_d = cnt_q - cnt_t'(1);
						else
							res_status = ST_NOTFOUND;
					end
					REQ_DUMP: begin
						if (cnt_q == '0) begin
							res_v      = 1'b1;
							res_item   = '0;
							res_status = ST_EMPTY;
						end else begin
							state_d = S_DUMP;
							idx_d   = '0;
						end
					end
					default: ;
				endcase
			end
			S_DUMP: begin
				res_v    = 1'b1;
				res_item = head;
				res_last = dump_last;
				cmd.op   = OP_ROT;
				idx_d    = idx_q + idx_t'(1);
				if (dump_last)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign cnt_wide = {5'b0, cnt_d};

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			valid_q <= res_v;
		end
	end

	// Request capture and result payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req_type;
			key_q <= value;
		end
		if (res_v) begin
			item_q   <= res_item;
			count_q  <= cnt_wide[COUNT_W-1:0];
			status_q <= res_status;
			last_q   <= res_last;
		end
	end

	assign valid  = valid_q;
	assign item   = item_q;
	assign count  = count_q;
	assign status = status_q;
	assign last   = last_q;

	// Result beats only follow a cycle of work
	a_beat_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> $past(state_q != S_IDLE))
		else $error("result beat without preceding work");

	// Held count never passes capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(CAPACITY))
		else $error("held count above capacity");

	// A non-full insert grows the list by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && req_q == REQ_INS && !full)
		|=> cnt_q == $past(cnt_q) + cnt_t'(1))
		else $error("insert did not grow the list");

	// Dump index stays inside the held range, and the count is frozen
	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> (cnt_t'(idx_q) < cnt_q) && $stable(cnt_q))
		else $error("dump index out of range");

	// Every dump ends with a beat marked last
	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP && state_d == S_IDLE) |=> valid_q && last_q)
		else $error("dump ended without last beat");

endmodule

FILE: hdl/sle_cell.sv
// One list cell: holds a single value and trades it with its neighbors.
// Depends on sle_pkg.
module sle_cell import sle_pkg::*; (
	input  logic     clk,
	input  sle_cmd_t cmd,
	input  logic     valid,
	input  val_t     left_val,
	input  logic     left_gt,
	input  val_t     right_val,
	input  logic     right_valid,
	input  val_t     head,
	input  logic     found_in,
	output val_t     val,
	output logic     gt,
	output logic     found_out
);

	val_t val_q;
	logic match;

	// Compare against the broadcast key
	always_comb begin
		gt        = valid && (val_q > cmd.key);
		match     = valid && (val_q == cmd.key);
		found_out = found_in | match;
	end

	// Insert shifts right past the key, delete shifts left from the first match,
	// rotate walks the held values toward the head
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_HOLD: val_q <= val_q;
			OP_INS: begin
				if (!valid || gt)
					val_q <= left_gt ? left_val : cmd.key;
			end
			OP_DEL: begin
				if (found_out)
					val_q <= right_val;
			end
			OP_ROT: begin
				if (valid)
					val_q <= right_valid ? right_val : head;
			end
		endcase
	end

	assign val = val_q;

endmodule

FILE: hdl/sle_chain.sv
// Row of CAPACITY cells with neighbor wiring and occupancy decode.
// Depends on sle_pkg and sle_cell.
module sle_chain import sle_pkg::*; (
	input  logic     clk,
	input  sle_cmd_t cmd,
	input  cnt_t     cnt,
	output val_t     head,
	output logic     found
);

	val_t                vals [CAPACITY];
	logic [CAPACITY-1:0] gts;
	logic [CAPACITY-1:0] founds;
	logic [CAPACITY-1:0] valids;

	assign head  = vals[0];
	assign found = founds[CAPACITY-1];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		val_t lval;
		logic lgt;
		val_t rval;
		logic rvalid;
		logic fin;

		// Occupancy is a thermometer of the held count
		assign valids[i] = cnt_t'(i) < cnt;

		if (i == 0) begin : g_first
			assign lval = cmd.key;
			assign lgt  = 1'b0;
			assign fin  = 1'b0;
		end else begin : g_inner
			assign lval = vals[i-1];
			assign lgt  = gts[i-1];
			assign fin  = founds[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rval   = vals[i];
			assign rvalid = 1'b0;
		end else begin : g_mid
			assign rval   = vals[i+1];
			assign rvalid = valids[i+1];
		end

		sle_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.valid      (valids[i]),
			.left_val   (lval),
			.left_gt    (lgt),
			.right_val  (rval),
			.right_valid(rvalid),
			.head       (head),
			.found_in   (fin),
			.val        (vals[i]),
			.gt         (gts[i]),
			.found_out  (founds[i])
		);
	end

endmodule

FILE: tb/sle_list_checker.sv
// Checker for sorted_list_engine_core: watches the request and result channels,
// keeps its own copy of the sorted list and compares every result beat.
// Depends on sle_pkg for types, codes and CAPACITY.
module sle_list_checker import sle_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] value,
	input  logic               valid,
	input  logic signed [31:0] item,
	input  logic [4:0]         count,
	input  logic [1:0]         status,
	input  logic               last,
	output int                 fails,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		val_t               item;
		logic [COUNT_W-1:0] count;
		logic [1:0]         status;
		logic               last;
	} list_beat_t;

	// shadow list, ascending, entries below held_num are valid
	val_t       held_vals [CAPACITY];
	int         held_num;
	list_beat_t due_beats [$];
	int         mismatches = 0;
	int         beat_no = 0;

	assign fails = mismatches;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: MISMATCH %s", $realtime, msg);
		mismatches++;
	endtask

	// queue one expected beat; count is taken after the list update
	function automatic void queue_beat(input val_t it, input logic [1:0] st, input logic lst);
		list_beat_t b;
		b.item   = it;
		b.count  = COUNT_W'(held_num);
		b.status = st;
		b.last   = lst;
		due_beats.push_back(b);
	endfunction

	// update the shadow list for one request and queue its beats
	function automatic void apply_request(input logic [1:0] rt, input val_t v);
		int pos;
		pos = 0;
		case (rt)
			REQ_INS: begin
				if (held_num >= CAPACITY) begin
					queue_beat(v, ST_FULL, 1'b1);
				end else begin
					// goes after every held value not greater than v
					while (pos < held_num && held_vals[pos] <= v)
						pos++;
					for (int i = held_num; i > pos; i--)
						held_vals[i] = held_vals[i-1];
					held_vals[pos] = v;
					held_num++;
					queue_beat(v, ST_OK, 1'b1);
				end
			end
			REQ_DEL: begin
				while (pos < held_num && held_vals[pos] !== v)
					pos++;
				if (pos == held_num) begin
					queue_beat(v, ST_NOTFOUND, 1'b1);
				end else begin
					for (int i = pos; i < held_num - 1; i++)
						held_vals[i] = held_vals[i+1];
					held_num--;
					queue_beat(v, ST_OK, 1'b1);
				end
			end
			REQ_DUMP: begin
				if (held_num == 0) begin
					queue_beat('0, ST_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < held_num; i++)
						queue_beat(held_vals[i], ST_OK, i == held_num - 1);
				end
			end
			default: ;	// unused code: no beat
		endcase
	endfunction

	// compare one result beat against the oldest expectation
	task automatic check_beat();
		list_beat_t exp_b;
		if (due_beats.size() == 0) begin
			report_mismatch($sformatf("beat %0d: unexpected result, item %0d count %0d status %0d",
				beat_no, item, count, status));
		end else begin
			exp_b = due_beats.pop_front();
			if (item !== exp_b.item)
				report_mismatch($sformatf("beat %0d: item %0d, expected %0d",
					beat_no, item, exp_b.item));
			if (count !== exp_b.count)
				report_mismatch($sformatf("beat %0d: count %0d, expected %0d",
					beat_no, count, exp_b.count));
			if (status !== exp_b.status)
				report_mismatch($sformatf("beat %0d: status %0d, expected %0d",
					beat_no, status, exp_b.status));
			if (last !== exp_b.last)
				report_mismatch($sformatf("beat %0d: last %b, expected %b",
					beat_no, last, exp_b.last));
		end
		beat_no++;
	endtask

	// results are checked before the request taken at the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_num = 0;
			due_beats.delete();
			pending <= 0;
		end else begin
			if (valid === 1'b1)
				check_beat();
			else if (valid !== 1'b0)
				report_mismatch("valid is unknown");
			if (start && busy === 1'b0)
				apply_request(req_type, value);
			pending <= due_beats.size();
		end
	end

endmodule

FILE: tb/tb_sorted_list_engine_core.sv
// Testbench top for sorted_list_engine_core: clock, reset, request stimulus and verdict.
// Depends on sle_pkg, sorted_list_engine_core and sle_list_checker.
module tb_sorted_list_engine_core import sle_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_NONE = 2'd3;	// unused request code
	localparam val_t VAL_MIN = 32'sh8000_0000;
	localparam val_t VAL_MAX = 32'sh7FFF_FFFF;
	localparam int STALL_LIMIT = 500;
	localparam int MAX_GAP = 30;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         req_type = REQ_INS;
	logic signed [31:0] value = '0;
	logic               valid;
	logic signed [31:0] item;
	logic [4:0]         count;
	logic [1:0]         status;
	logic               last;
	int                 fails;
	int                 pending;

	int   idle_pct = 0;
	val_t recent_vals [$];	// recently inserted values, used as delete targets

	always #10 clk = ~clk;

	sorted_list_engine_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.value    (value),
		.valid    (valid),
		.item     (item),
		.count    (count),
		.status   (status),
		.last     (last)
	);

	sle_list_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.value    (value),
		.valid    (valid),
		.item     (item),
		.count    (count),
		.status   (status),
		.last     (last),
		.fails    (fails),
		.pending  (pending)
	);

	// one request beat, after a random idle gap; start stays high on return
	task automatic send_req(input logic [1:0] rt, input val_t v);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start    <= 1'b0;
			req_type <= 2'($urandom_range(3));
			value    <= $urandom;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		req_type <= rt;
		value    <= v;
		do @(posedge clk); while (busy !== 1'b0);
		if (rt == REQ_INS) begin
			recent_vals.push_back(v);
			if (recent_vals.size() > 32)
				void'(recent_vals.pop_front());
		end
	endtask

	// hold off until every expected beat has arrived
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// mostly a small range so duplicates and delete hits are common
	function automatic val_t pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return val_t'($signed($urandom_range(6)) - 3);
		if (r < 70) begin
			case ($urandom_range(3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return -1;
				default: return VAL_MIN + 1;
			endcase
		end
		return val_t'($urandom);
	endfunction

	function automatic val_t pick_victim();
		if (recent_vals.size() > 0 && $urandom_range(99) < 60)
			return recent_vals[$urandom_range(recent_vals.size() - 1)];
		return pick_value();
	endfunction

	// stimulus: directed corner cases, then three random phases
	initial begin
		int         k;
		int         r;
		bit         grow;
		logic [1:0] rt;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 34;
		// empty list: dump and delete
		send_req(REQ_DUMP, VAL_MAX);
		send_req(REQ_DEL, 0);
		// extremes and a duplicate
		send_req(REQ_INS, VAL_MAX);
		send_req(REQ_INS, VAL_MIN);
		send_req(REQ_INS, 0);
		send_req(REQ_INS, -1);
		send_req(REQ_INS, 1);
		send_req(REQ_INS, 0);
		send_req(REQ_DUMP, 0);
		send_req(REQ_DEL, 0);
		send_req(REQ_DEL, 7);
		send_req(REQ_NONE, -1);
		send_req(REQ_DUMP, -1);
		// fill to capacity, then one insert too many
		for (int i = 0; i < CAPACITY - 5; i++)
			send_req(REQ_INS, (i % 2) ? val_t'(32'hAAAA_AAAA) : val_t'(32'h5555_5555));
		send_req(REQ_INS, 5);
		send_req(REQ_DUMP, 0);
		drain_results();

		// random phases: grow toward full, then shrink toward empty
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 34 : (ph == 1) ? 51 : 0;
			k = 0;
			while (k < 48) begin
				grow = ((k / 24) % 2) == 0;
				r = $urandom_range(99);
				if (r < 3) begin
					send_req(REQ_NONE, pick_value());
				end else begin
					if (r < 13)
						rt = REQ_DUMP;
					else if (r < (grow ? 78 : 28))
						rt = REQ_INS;
					else
						rt = REQ_DEL;
					send_req(rt, (rt == REQ_DEL) ? pick_victim() : pick_value());
					k++;
				end
			end
			drain_results();
		end

		repeat (24) @(posedge clk);
		if (fails == 0)
			$display("tb_sorted_list_engine_core passed");
		else
			$display("tb_sorted_list_engine_core failed");
		$finish;
	end

	// watchdog: too many cycles with no beat on either channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (arst_n && !((start && busy === 1'b0) || valid === 1'b1))
				quiet++;
			else
				quiet = 0;
		end
		$display("tb_sorted_list_engine_core failed");
		$finish;
	end

endmodule
